/* design/frt_pkg.sv */
`timescale 1ns / 1ps
package frt_pkg;

  localparam int unsigned HEADER_BYTES = 16;
  localparam logic [11:0] MAX_STRIDE_RESET = 12'd1400;
  localparam logic [31:0] EXPIRE_RESET = 32'd19200000;

  localparam logic [0:0] REG_MAX_STRIDE = 1'b0;
  localparam logic [0:0] REG_EXPIRE = 1'b1;

  localparam logic [2:0] ST_PARTIAL = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_MALFORMED = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_DUPLICATE = 3'd4;

  typedef struct packed {
    logic [11:0] frame_len;
    logic [31:0] source_addr;
    logic [15:0] datagram_id;
    logic [7:0]  part_index;
    logic [7:0]  part_count;
    logic [15:0] chunk_len;
    logic [15:0] stride;
    logic [47:0] now_time;
  } frag_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  slot;
    logic [13:0] write_offset;
    logic [11:0] copy_len;
    logic [13:0] rebuilt_len;
  } frag_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic locate;
    logic update;
    logic finish;
  } frt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic malformed;
  } frt_stat_t;

endpackage

/* design/frt_ctrl.sv */
`timescale 1ns / 1ps
module frt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  frt_pkg::frt_stat_t stat,
  output frt_pkg::frt_cmd_t cmd
);
  import frt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_LOCATE = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
        if (start) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_LOCATE;
      end
      S_LOCATE: begin
        // A malformed header touches no state and goes straight to the result.
        if (stat.malformed) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.locate = 1'b1;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

/* design/frt_datapath.sv */
`timescale 1ns / 1ps
module frt_datapath #(
  parameter int ENTRY_COUNT = 4,
  parameter int MAX_PARTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  frt_pkg::frt_cmd_t  cmd,
  output frt_pkg::frt_stat_t stat,
  input  frt_pkg::frag_in_t  in_item,
  input  logic [11:0]        max_stride,
  input  logic [31:0]        expire_ticks,
  output logic               out_valid,
  output frt_pkg::frag_out_t out_item
);
  import frt_pkg::*;

  localparam int SW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int TW = $clog2(MAX_PARTS + 1);

  frag_in_t item_r;
  logic     bad_r;

  logic             valid_r    [ENTRY_COUNT];
  logic [31:0]      src_r      [ENTRY_COUNT];
  logic [15:0]      ident_r    [ENTRY_COUNT];
  logic [MAX_PARTS-1:0] mask_r [ENTRY_COUNT];
  logic [11:0]      estride_r  [ENTRY_COUNT];
  logic [TW-1:0]    etotal_r   [ENTRY_COUNT];
  logic [47:0]      touch_r    [ENTRY_COUNT];
  logic [11:0]      plen_r     [ENTRY_COUNT][MAX_PARTS];

  logic [SW-1:0] slot_r;
  logic          fresh_r;
  logic [2:0]    status_r;
  logic [13:0]   offset_r;
  logic [13:0]   rebuilt_r;
  logic          out_valid_r;
  frag_out_t     out_r;

  // Header checks.
  logic bad_c;
  always_comb begin
    bad_c = (item_r.part_count == 8'd0) || (item_r.part_index >= item_r.part_count) ||
            ({24'd0, item_r.part_count} > 32'(MAX_PARTS)) ||
            (item_r.stride == 16'd0) || (item_r.stride > {4'd0, max_stride}) ||
            (item_r.chunk_len > item_r.stride) ||
            ({5'd0, item_r.frame_len} < (17'(item_r.chunk_len) + 17'(HEADER_BYTES)));
  end
  assign stat.malformed = bad_r;

  // Expiry, match and victim choice over the live entries.
  logic [ENTRY_COUNT-1:0] live_c;
  logic          hit_c;
  logic [SW-1:0] hit_idx_c, pick_c;
  logic          free_found_c;
  logic [47:0]   oldest_c;
  logic [47:0]   age_c [ENTRY_COUNT];
  always_comb begin
    hit_c = 1'b0;
    hit_idx_c = '0;
    pick_c = '0;
    free_found_c = 1'b0;
    oldest_c = touch_r[0];
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      age_c[i] = item_r.now_time - touch_r[i];
      live_c[i] = valid_r[i] && !((item_r.now_time > touch_r[i]) &&
                  (age_c[i] > {16'd0, expire_ticks}));
    end
    for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
      if (live_c[i] && src_r[i] == item_r.source_addr &&
          ident_r[i] == item_r.datagram_id) begin
        hit_c = 1'b1;
        hit_idx_c = SW'(i);
      end
    end
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      if (!free_found_c) begin
        if (!live_c[i]) begin
          pick_c = SW'(i);
          free_found_c = 1'b1;
        end else if (touch_r[i] < oldest_c) begin
          oldest_c = touch_r[i];
          pick_c = SW'(i);
        end
      end
    end
  end

  // Update step on the chosen slot.
  logic [MAX_PARTS-1:0] mask_c, bit_c, want_c, newmask_c;
  logic [11:0]   est_c;
  logic [TW-1:0] etot_c;
  logic [PW-1:0] pidx_c, lastidx_c;
  logic [11:0]   lastlen_c;
  logic          mism_c, dup_c, done_c;
  logic [TW-1:0] tot_c;
  always_comb begin
    pidx_c = item_r.part_index[PW-1:0];
    tot_c = item_r.part_count[TW-1:0];
    mask_c = fresh_r ? '0 : mask_r[slot_r];
    est_c = estride_r[slot_r];
    etot_c = etotal_r[slot_r];
    bit_c = '0;
    bit_c[pidx_c] = 1'b1;
    want_c = '0;
    for (int p = 0; p < MAX_PARTS; p++) want_c[p] = (32'(p) < 32'(tot_c));
    mism_c = (mask_c != '0) && (({4'd0, est_c} != item_r.stride) || (etot_c != tot_c));
    dup_c = (mask_c & bit_c) != '0;
    newmask_c = mask_c | bit_c;
    done_c = (newmask_c == want_c);
    lastidx_c = PW'(tot_c - TW'(1));
    lastlen_c = (lastidx_c == pidx_c) ? item_r.chunk_len[11:0] : plen_r[slot_r][lastidx_c];
  end

  logic [13:0] offset_c, base_c;
  assign offset_c = 14'(item_r.part_index * item_r.stride);
  assign base_c = 14'(14'(tot_c - TW'(1)) * item_r.stride[13:0]);

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.check) bad_r <= bad_c;
    if (cmd.locate) begin
      slot_r <= hit_c ? hit_idx_c : pick_c;
      fresh_r <= !hit_c;
    end
    if (cmd.update) begin
      offset_r <= offset_c;
      rebuilt_r <= 14'(base_c + 14'(lastlen_c));
      status_r <= mism_c ? ST_MISMATCH : dup_c ? ST_DUPLICATE :
                  done_c ? ST_COMPLETE : ST_PARTIAL;
    end
    if (cmd.finish) begin
      if (bad_r) begin
        out_r <= '{status: ST_MALFORMED, slot: 2'd0, write_offset: 14'd0,
                   copy_len: 12'd0, rebuilt_len: 14'd0};
      end else begin
        out_r.status <= status_r;
        out_r.slot <= 2'(slot_r);
        out_r.write_offset <= (status_r <= ST_COMPLETE) ? offset_r : 14'd0;
        out_r.copy_len <= (status_r <= ST_COMPLETE) ? item_r.chunk_len[11:0] : 12'd0;
        out_r.rebuilt_len <= (status_r == ST_COMPLETE) ? rebuilt_r : 14'd0;
      end
    end
  end

  // Table state; expiry and claim are committed in the locate step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        valid_r[i] <= 1'b0;
        mask_r[i] <= '0;
        estride_r[i] <= '0;
        etotal_r[i] <= '0;
        touch_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.locate) begin
        for (int i = 0; i < ENTRY_COUNT; i++)
          valid_r[i] <= live_c[i] || (!hit_c && (pick_c == SW'(i)));
        if (!hit_c) begin
          src_r[pick_c] <= item_r.source_addr;
          ident_r[pick_c] <= item_r.datagram_id;
          mask_r[pick_c] <= '0;
          estride_r[pick_c] <= '0;
          etotal_r[pick_c] <= '0;
          touch_r[pick_c] <= item_r.now_time;
        end
      end
      if (cmd.update && !mism_c && !dup_c) begin
        if (mask_c == '0) begin
          estride_r[slot_r] <= item_r.stride[11:0];
          etotal_r[slot_r] <= tot_c;
        end
        mask_r[slot_r] <= newmask_c;
        touch_r[slot_r] <= item_r.now_time;
        plen_r[slot_r][pidx_c] <= item_r.chunk_len[11:0];
        if (done_c) valid_r[slot_r] <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;
endmodule

/* design/fragment_reassembly_tracker.sv */
`timescale 1ns / 1ps
// The result is registered: out_valid rises after the finish step, which follows the check,
// locate and update steps for a well-formed header and the check step for a malformed one.
// One header at a time: a new header is taken only while the controller is idle, and the
// steps run over the register-based entry table; busy is high while a header is in work.
// Reset (rst_n low, synchronous) empties the table and loads the default stride and timeout.
// The result strobe lasts one cycle; the receiver cannot stall it.
module fragment_reassembly_tracker #(
  parameter int ENTRY_COUNT = 4,
  parameter int MAX_PARTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  frt_pkg::frag_in_t  in_item,
  output logic               out_valid,
  output frt_pkg::frag_out_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import frt_pkg::*;

  logic [11:0] max_stride_r;
  logic [31:0] expire_r;
  frt_cmd_t  cmd;
  frt_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_stride_r <= MAX_STRIDE_RESET;
      expire_r <= EXPIRE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_STRIDE: max_stride_r <= cfg_data[11:0];
        REG_EXPIRE: expire_r <= cfg_data;
        default: ;
      endcase
    end
  end

  frt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  frt_datapath #(.ENTRY_COUNT(ENTRY_COUNT), .MAX_PARTS(MAX_PARTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_item(in_item),
    .max_stride(max_stride_r), .expire_ticks(expire_r),
    .out_valid(out_valid), .out_item(out_item)
  );

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status <= ST_DUPLICATE)) else $error("bad status code");
endmodule

/* tb/fragment_reassembly_tracker_tb.sv */
`timescale 1ns / 1ps
module fragment_reassembly_tracker_tb;
  import frt_pkg::*;

  localparam int SLOTS = 4;
  localparam int PARTS = 4;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  frag_in_t in_item = '0;
  logic out_valid;
  frag_out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  fragment_reassembly_tracker DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [11:0] lim_stride;
  logic [31:0] age_limit;
  logic        tb_valid [SLOTS];
  logic [31:0] tb_src [SLOTS];
  logic [15:0] tb_id [SLOTS];
  logic [3:0]  tb_seen [SLOTS];
  logic [15:0] tb_stride [SLOTS];
  logic [7:0]  tb_total [SLOTS];
  logic [47:0] tb_touch [SLOTS];
  logic [11:0] tb_len [SLOTS][PARTS];

  frag_in_t  pending_frags[$];
  frag_out_t expected_results[$];
  int errors = 0;
  int pending_cfg = 0;
  logic cfg_req = 1'b0;
  logic [0:0] cfg_req_idx;
  logic [31:0] cfg_req_data;
  int quiet_cycles = 0;
  logic driver_idle;
  logic busy_at_edge = 1'b0;
  logic cfg_done_edge = 1'b0;

  function automatic frag_out_t track_fragment(frag_in_t f);
    frag_out_t r;
    int s;
    logic [47:0] oldest;
    logic found;
    r = '0;
    r.status = ST_MALFORMED;
    if (f.part_count == 0 || f.part_index >= f.part_count || f.part_count > PARTS) return r;
    if (f.stride == 0 || f.stride > {4'd0, lim_stride}) return r;
    if (f.chunk_len > f.stride || {4'd0, f.frame_len} < 17'(HEADER_BYTES) + f.chunk_len)
      return r;
    for (int i = 0; i < SLOTS; i++)
      if (tb_valid[i] && f.now_time > tb_touch[i] &&
          (f.now_time - tb_touch[i]) > {16'd0, age_limit})
        tb_valid[i] = 1'b0;
    found = 1'b0;
    s = 0;
    for (int i = 0; i < SLOTS; i++)
      if (!found && tb_valid[i] && tb_src[i] == f.source_addr && tb_id[i] == f.datagram_id) begin
        s = i;
        found = 1'b1;
      end
    if (!found) begin
      oldest = tb_touch[0];
      for (int i = 0; i < SLOTS; i++) begin
        if (!tb_valid[i]) begin
          s = i;
          break;
        end
        if (tb_touch[i] < oldest) begin
          oldest = tb_touch[i];
          s = i;
        end
      end
      tb_valid[s] = 1'b1;
      tb_src[s] = f.source_addr;
      tb_id[s] = f.datagram_id;
      tb_seen[s] = '0;
      tb_stride[s] = '0;
      tb_total[s] = '0;
      tb_touch[s] = f.now_time;
      for (int p = 0; p < PARTS; p++) tb_len[s][p] = '0;
    end
    r.slot = 2'(s);
    if (tb_seen[s] == 0) begin
      tb_stride[s] = f.stride;
      tb_total[s] = f.part_count;
    end else if (tb_stride[s] != f.stride || tb_total[s] != f.part_count) begin
      r.status = ST_MISMATCH;
      return r;
    end
    if (tb_seen[s][f.part_index]) begin
      r.status = ST_DUPLICATE;
      return r;
    end
    tb_len[s][f.part_index] = f.chunk_len[11:0];
    tb_seen[s][f.part_index] = 1'b1;
    tb_touch[s] = f.now_time;
    r.status = ST_PARTIAL;
    if (tb_seen[s] == 4'((1 << f.part_count) - 1)) begin
      r.rebuilt_len = 14'((f.part_count - 1) * f.stride + tb_len[s][f.part_count - 1]);
      tb_valid[s] = 1'b0;
      r.status = ST_COMPLETE;
    end
    r.write_offset = 14'(f.part_index * f.stride);
    r.copy_len = f.chunk_len[11:0];
    return r;
  endfunction

  // Driver: one item at a time with a random gap ahead of each.
  int gap = 0;
  logic gap_drawn = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !busy_at_edge) begin
        start <= 1'b0;
      end else if (!start && pending_frags.size() > 0 && !cfg_req) begin
        if (!gap_drawn) begin
          gap = $urandom_range(0, 15);
          if ($urandom_range(0, 3) == 0) gap = 0;
          gap_drawn = 1'b1;
        end
        if (gap > 0) begin
          gap--;
        end else begin
          in_item <= pending_frags.pop_front();
          start <= 1'b1;
          gap_drawn = 1'b0;
        end
      end
    end
  end

  // Acceptance is decided at the rising edge; the driver reads it at the next falling edge.
  logic accepted;
  always @(posedge clk) begin
    accepted = rst_n && start && !busy;
    busy_at_edge <= !accepted;
    if (accepted) expected_results.push_back(track_fragment(in_item));
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MAX_STRIDE) lim_stride = cfg_data[11:0];
      else age_limit = cfg_data;
    end
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        frag_out_t e;
        e = expected_results.pop_front();
        if (out_item.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_item.status); errors++;
        end
        if (out_item.slot !== e.slot && e.status != ST_MALFORMED) begin
          $error("slot expected %0d got %0d", e.slot, out_item.slot); errors++;
        end
        if (e.status == ST_MALFORMED && out_item.slot !== e.slot) begin
          $error("slot expected %0d got %0d", e.slot, out_item.slot); errors++;
        end
        if (out_item.write_offset !== e.write_offset) begin
          $error("write_offset expected %0d got %0d", e.write_offset, out_item.write_offset);
          errors++;
        end
        if (out_item.copy_len !== e.copy_len) begin
          $error("copy_len expected %0d got %0d", e.copy_len, out_item.copy_len); errors++;
        end
        if (out_item.rebuilt_len !== e.rebuilt_len) begin
          $error("rebuilt_len expected %0d got %0d", e.rebuilt_len, out_item.rebuilt_len);
          errors++;
        end
      end
    end
    if (accepted || out_valid || (cfg_valid && cfg_ready) || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Configuration writer, driven on falling edges.
  always @(negedge clk) begin
    if (cfg_valid && cfg_done_edge) begin
      cfg_valid <= 1'b0;
    end else if (cfg_req && !cfg_valid) begin
      cfg_index <= cfg_req_idx;
      cfg_data <= cfg_req_data;
      cfg_valid <= 1'b1;
    end
  end
  always @(posedge clk) begin
    cfg_done_edge <= cfg_valid && cfg_ready;
    if (cfg_valid && cfg_ready) cfg_req = 1'b0;
  end

  task automatic wait_drained();
    while (pending_frags.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    wait_drained();
    cfg_req_idx = idx;
    cfg_req_data = val;
    cfg_req = 1'b1;
    while (cfg_req) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic frag_in_t make_frag(logic [31:0] src, logic [15:0] id, int part,
                                         int cnt, int strd, logic [47:0] now);
    frag_in_t f;
    f.source_addr = src;
    f.datagram_id = id;
    f.part_index = 8'(part);
    f.part_count = 8'(cnt);
    f.stride = 16'(strd);
    f.chunk_len = 16'($urandom_range(0, strd));
    f.frame_len = 12'($urandom_range(16 + f.chunk_len, 4095));
    f.now_time = now;
    return f;
  endfunction

  logic [47:0] clock_now = 48'd1000;

  task automatic push_datagram(int keys);
    logic [31:0] src;
    logic [15:0] id;
    int cnt, strd, order[$], t;
    frag_in_t f;
    src = (keys > 0) ? 32'($urandom_range(1, keys)) : $urandom();
    id = (keys > 0) ? 16'($urandom_range(1, keys)) : 16'($urandom());
    cnt = $urandom_range(1, PARTS);
    strd = $urandom_range(1, lim_stride < 4000 ? lim_stride : 4000);
    for (int p = 0; p < cnt; p++) order.push_back(p);
    order.shuffle();
    foreach (order[k]) begin
      clock_now += 48'($urandom_range(0, 3000));
      f = make_frag(src, id, order[k], cnt, strd, clock_now);
      t = $urandom_range(0, 19);
      if (t == 0) f.part_index = 8'($urandom_range(0, cnt - 1));
      else if (t == 1) f.stride = 16'($urandom_range(f.chunk_len, 4000) | 1);
      else if (t == 2) f.part_count = 8'($urandom_range(1, PARTS));
      pending_frags.push_back(f);
    end
  endtask

  initial begin
    frag_in_t f;
    lim_stride = MAX_STRIDE_RESET;
    age_limit = EXPIRE_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      tb_valid[i] = 0; tb_seen[i] = 0; tb_stride[i] = 0; tb_total[i] = 0; tb_touch[i] = 0;
      tb_src[i] = 0; tb_id[i] = 0;
      for (int p = 0; p < PARTS; p++) tb_len[i][p] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Malformed cases.
    f = make_frag(32'hFFFFFFFF, 16'hFFFF, 0, 0, 100, 48'd10); pending_frags.push_back(f);
    f = make_frag(1, 1, 4, 4, 100, 48'd10); pending_frags.push_back(f);
    f = make_frag(1, 1, 0, 5, 100, 48'd10); pending_frags.push_back(f);
    f = make_frag(1, 1, 255, 255, 100, 48'd10); pending_frags.push_back(f);
    f = make_frag(1, 1, 0, 1, 100, 48'd10); f.stride = 0; f.chunk_len = 0;
    pending_frags.push_back(f);
    f = make_frag(1, 1, 0, 1, 1401, 48'd10); pending_frags.push_back(f);
    f = make_frag(1, 1, 0, 1, 65535, 48'd10); pending_frags.push_back(f);
    f = make_frag(1, 1, 0, 1, 100, 48'd10); f.chunk_len = 101; f.frame_len = 4095;
    pending_frags.push_back(f);
    f = make_frag(1, 1, 0, 1, 100, 48'd10); f.chunk_len = 50; f.frame_len = 65;
    pending_frags.push_back(f);
    // Single-part, full four-part with duplicate and mismatch.
    f = make_frag(2, 2, 0, 1, 1400, 48'd20); f.chunk_len = 1400; f.frame_len = 4095;
    pending_frags.push_back(f);
    pending_frags.push_back(make_frag(3, 3, 3, 4, 1400, 48'd30));
    pending_frags.push_back(make_frag(3, 3, 3, 4, 1400, 48'd31));
    pending_frags.push_back(make_frag(3, 3, 1, 4, 1399, 48'd32));
    pending_frags.push_back(make_frag(3, 3, 1, 3, 1400, 48'd33));
    pending_frags.push_back(make_frag(3, 3, 0, 4, 1400, 48'd34));
    pending_frags.push_back(make_frag(3, 3, 1, 4, 1400, 48'd35));
    pending_frags.push_back(make_frag(3, 3, 2, 4, 1400, 48'd36));
    // Fill all slots, then evict; then a backwards clock and a long-idle expiry.
    for (int k = 0; k < 5; k++)
      pending_frags.push_back(make_frag(10 + k, 7, 0, 2, 64, 48'(40 + k)));
    pending_frags.push_back(make_frag(11, 7, 1, 2, 64, 48'd5));
    pending_frags.push_back(make_frag(12, 7, 1, 2, 64, 48'hFFFF_FFFF_FFFF));
    wait_drained();

    write_reg(REG_MAX_STRIDE, 32'd0);
    for (int k = 0; k < 4; k++) pending_frags.push_back(make_frag(5, 5, 0, 1, 1, 48'd99));
    write_reg(REG_MAX_STRIDE, 32'hFFFF_FFFF);
    write_reg(REG_EXPIRE, 32'd0);
    for (int k = 0; k < 6; k++) push_datagram(2);
    write_reg(REG_EXPIRE, 32'hFFFF_FFFF);
    for (int k = 0; k < 6; k++) push_datagram(0);
    write_reg(REG_MAX_STRIDE, 32'd1);
    for (int k = 0; k < 6; k++) push_datagram(3);

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_MAX_STRIDE, 32'($urandom_range(1, 4095)));
      write_reg(REG_EXPIRE, phase[0] ? 32'($urandom_range(500, 20000)) : $urandom());
      while (pending_frags.size() < 330) begin
        if ($urandom_range(0, 9) == 0) begin
          f = frag_in_t'($bits(frag_in_t)'({$urandom(), $urandom(), $urandom(),
                                            $urandom(), $urandom()}));
          if ($urandom_range(0, 1)) f.now_time = clock_now;
          pending_frags.push_back(f);
        end else begin
          push_datagram(phase[1] ? 0 : 6);
        end
      end
      wait_drained();
    end
    wait_drained();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
